[hdl/armmp_pkg.sv]
// Package for the affine recurrence matrix-power block.
// Operand width, matrix types, reduction request/response types and sequencer state codes. No dependencies.
`default_nettype none
package armmp_pkg;
    localparam int OPERAND_BITS = 30;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int ACC_BITS     = PROD_BITS + 1;

    typedef logic [OPERAND_BITS-1:0] opnd_t;
    typedef opnd_t [8:0] mat_t;

    // modular reduction unit request/response
    typedef struct packed {
        logic              start;
        logic [ACC_BITS-1:0] value;
        opnd_t             modulus;
    } red_req_t;

    typedef struct packed {
        logic  done;
        opnd_t rem;
    } red_rsp_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PREP  = 10'b0000000010,
        ST_MUL   = 10'b0000000100,
        ST_RED   = 10'b0000001000,
        ST_NEXT  = 10'b0000010000,
        ST_FIN0  = 10'b0000100000,
        ST_FIN1  = 10'b0001000000,
        ST_FRED  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_BIT   = 10'b1000000000
    } state_t;
endpackage
`default_nettype wire

[hdl/armmp_if.sv]
// Valid/ready channel interfaces for the request and result sides.
// Depends on armmp_pkg for the operand type.
`default_nettype none
interface armmp_in_if (input wire logic clk);
    logic                   valid;
    logic                   ready;
    armmp_pkg::opnd_t       coef_a;
    armmp_pkg::opnd_t       coef_b;
    armmp_pkg::opnd_t       addend_c;
    armmp_pkg::opnd_t       term_index;
    armmp_pkg::opnd_t       modulus;
    modport source (output valid, coef_a, coef_b, addend_c, term_index, modulus,
                    input ready);
    modport sink (input valid, coef_a, coef_b, addend_c, term_index, modulus,
                  output ready);
endinterface

interface armmp_out_if (input wire logic clk);
    logic             valid;
    logic             ready;
    armmp_pkg::opnd_t term_value;
    modport source (output valid, term_value, input ready);
    modport sink (input valid, term_value, output ready);
endinterface
`default_nettype wire

[hdl/armmp_modred.sv]
// Bit-serial restoring reduction: value mod modulus, one quotient bit a cycle.
// Depends on armmp_pkg.
`default_nettype none
module armmp_modred (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire armmp_pkg::red_req_t req,
    output armmp_pkg::red_rsp_t      rsp
);
    localparam int AB = armmp_pkg::ACC_BITS;
    localparam int CW = $clog2(AB + 1);

    logic [AB-1:0]                 val_reg, val_next;
    logic [armmp_pkg::OPERAND_BITS:0] rem_reg, rem_next;
    armmp_pkg::opnd_t              mod_reg, mod_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [armmp_pkg::OPERAND_BITS+1:0] shifted, diff;

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, val_reg[AB-1]};
        diff      = shifted - {2'b00, mod_reg};
        if (req.start)
        begin
            val_next  = req.value;
            mod_next  = req.modulus;
            rem_next  = '0;
            cnt_next  = CW'(AB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = val_reg << 1;
            if (!diff[armmp_pkg::OPERAND_BITS+1])
                rem_next = diff[armmp_pkg::OPERAND_BITS:0];
            else
                rem_next = shifted[armmp_pkg::OPERAND_BITS:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[armmp_pkg::OPERAND_BITS-1:0];
endmodule
`default_nettype wire

[hdl/affine_recurrence_mod_matrix_power.sv]
// Affine recurrence g(n) mod m by 3x3 matrix square-and-multiply.
// n <= 2 or m == 0 gives the result the cycle after the request is taken.
// Otherwise each multiply-accumulate is a multiply, a bit-serial reduction and
// a step, and a matrix product is 27 of them; every bit of n-2 costs a squaring
// plus a product when the bit is set. Operand prep comes before the bit loop
// and the final dot product after it.
// Throughput: one request at a time; ready again once the result is taken.
// rst_n (async, low) returns the sequencer to idle.
`default_nettype none
module affine_recurrence_mod_matrix_power (
    input  wire logic  clk,
    input  wire logic  rst_n,
    armmp_in_if.sink   in_ch,
    armmp_out_if.source out_ch
);
    localparam int OB = armmp_pkg::OPERAND_BITS;
    localparam int PB = armmp_pkg::PROD_BITS;
    localparam int AB = armmp_pkg::ACC_BITS;

    armmp_pkg::state_t state_reg, state_next;
    armmp_pkg::mat_t   acc_reg, acc_next;    // running power
    armmp_pkg::mat_t   base_reg, base_next;  // repeated square
    armmp_pkg::mat_t   tmp_reg, tmp_next;    // product being built
    armmp_pkg::opnd_t  m_reg, m_next;
    armmp_pkg::opnd_t  c_reg, c_next;
    armmp_pkg::opnd_t  e_reg, e_next;        // remaining exponent
    armmp_pkg::opnd_t  res_reg, res_next;
    armmp_pkg::opnd_t  part_reg, part_next;  // running MAC value, reduced
    logic [PB-1:0]     prod_reg, prod_next;
    logic              sq_reg, sq_next;      // 0: acc*base, 1: base*base
    logic [1:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [2:0]        fstep_reg, fstep_next;   // pre-reduction / final steps
    logic              valid_reg, valid_next;

    armmp_pkg::red_req_t rreq;
    armmp_pkg::red_rsp_t rrsp;
    armmp_pkg::opnd_t    opx, opy;
    logic [3:0]          xi, yi;
    logic [PB-1:0]       mul_p;

    armmp_modred u_red (.clk(clk), .rst_n(rst_n), .req(rreq), .rsp(rrsp));

    // operand selection for the single multiplier
    always_comb
    begin
        xi  = 4'(i_reg) * 4'd3 + 4'(k_reg);
        yi  = 4'(k_reg) * 4'd3 + 4'(j_reg);
        opx = sq_reg ? base_reg[xi] : acc_reg[xi];
        opy = base_reg[yi];
        // final step reuses the multiplier for c * acc02
        if (state_reg == armmp_pkg::ST_FIN1)
        begin
            opx = acc_reg[2];
            opy = c_reg;
        end
        mul_p = PB'(opx) * PB'(opy);
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        tmp_next   = tmp_reg;
        m_next     = m_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        res_next   = res_reg;
        part_next  = part_reg;
        prod_next  = prod_reg;
        sq_next    = sq_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        fstep_next = fstep_reg;
        valid_next = valid_reg;
        rreq.start   = 1'b0;
        rreq.value   = '0;
        rreq.modulus = m_reg;
        case (state_reg)
            armmp_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    m_next = in_ch.modulus;
                    c_next = in_ch.addend_c;
                    base_next = '0;
                    base_next[0] = in_ch.coef_a;
                    base_next[1] = in_ch.coef_b;
                    e_next = in_ch.term_index - OB'(2);
                    if (in_ch.modulus == '0)
                    begin
                        res_next   = '0;
                        valid_next = 1'b1;
                        state_next = armmp_pkg::ST_OUT;
                    end
                    else if (in_ch.term_index <= OB'(2))
                    begin
                        res_next   = (in_ch.modulus == OB'(1)) ? '0 : OB'(1);
                        valid_next = 1'b1;
                        state_next = armmp_pkg::ST_OUT;
                    end
                    else
                    begin
                        fstep_next = 3'd0;
                        state_next = armmp_pkg::ST_PREP;
                    end
                end
            end
            // reduce a, b, c mod m and build the start matrices
            armmp_pkg::ST_PREP:
            begin
                if (fstep_reg == 3'd0 || fstep_reg == 3'd2 || fstep_reg == 3'd4)
                begin
                    rreq.start = 1'b1;
                    rreq.value = (fstep_reg == 3'd0) ? AB'(base_reg[0]) :
                                 (fstep_reg == 3'd2) ? AB'(base_reg[1]) : AB'(c_reg);
                    fstep_next = fstep_reg + 3'd1;
                end
                else if (rrsp.done)
                begin
                    if (fstep_reg == 3'd1)
                        base_next[0] = rrsp.rem;
                    else if (fstep_reg == 3'd3)
                        base_next[1] = rrsp.rem;
                    else
                        c_next = rrsp.rem;
                    fstep_next = fstep_reg + 3'd1;
                    if (fstep_reg == 3'd5)
                    begin
                        base_next[2] = (m_reg == OB'(1)) ? '0 : OB'(1);
                        base_next[3] = (m_reg == OB'(1)) ? '0 : OB'(1);
                        base_next[8] = (m_reg == OB'(1)) ? '0 : OB'(1);
                        acc_next = '0;
                        acc_next[0] = (m_reg == OB'(1)) ? '0 : OB'(1);
                        acc_next[4] = (m_reg == OB'(1)) ? '0 : OB'(1);
                        acc_next[8] = (m_reg == OB'(1)) ? '0 : OB'(1);
                        state_next = armmp_pkg::ST_BIT;
                    end
                end
            end
            armmp_pkg::ST_BIT:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                part_next = '0;
                if (e_reg == '0)
                begin
                    state_next = armmp_pkg::ST_FIN0;
                end
                else
                begin
                    sq_next    = ~e_reg[0];
                    state_next = armmp_pkg::ST_MUL;
                end
            end
            armmp_pkg::ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = armmp_pkg::ST_RED;
                fstep_next = 3'd0;
            end
            armmp_pkg::ST_RED:
            begin
                if (fstep_reg == 3'd0)
                begin
                    rreq.start = 1'b1;
                    rreq.value = AB'(prod_reg) + AB'(part_reg);
                    fstep_next = 3'd1;
                end
                else if (rrsp.done)
                begin
                    part_next  = rrsp.rem;
                    state_next = armmp_pkg::ST_NEXT;
                end
            end
            armmp_pkg::ST_NEXT:
            begin
                state_next = armmp_pkg::ST_MUL;
                if (k_reg != 2'd2)
                begin
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    tmp_next[4'(i_reg) * 4'd3 + 4'(j_reg)] = part_reg;
                    part_next = '0;
                    k_next = '0;
                    if (j_reg != 2'd2)
                    begin
                        j_next = j_reg + 2'd1;
                    end
                    else
                    begin
                        j_next = '0;
                        if (i_reg != 2'd2)
                        begin
                            i_next = i_reg + 2'd1;
                        end
                        else
                        begin
                            i_next = '0;
                            if (sq_reg)
                            begin
                                base_next = tmp_next;
                                e_next    = e_reg >> 1;
                                state_next = armmp_pkg::ST_BIT;
                            end
                            else
                            begin
                                acc_next = tmp_next;
                                sq_next  = 1'b1;
                            end
                        end
                    end
                end
            end
            // v = (acc00 + acc01) mod m
            armmp_pkg::ST_FIN0:
            begin
                rreq.start = 1'b1;
                rreq.value = AB'(acc_reg[0]) + AB'(acc_reg[1]);
                state_next = armmp_pkg::ST_FIN1;
            end
            armmp_pkg::ST_FIN1:
            begin
                if (rrsp.done)
                begin
                    part_next  = rrsp.rem;
                    prod_next  = mul_p;
                    state_next = armmp_pkg::ST_FRED;
                    fstep_next = 3'd0;
                end
            end
            // c*acc02 + v reduced once gives the same residue
            armmp_pkg::ST_FRED:
            begin
                if (fstep_reg == 3'd0)
                begin
                    rreq.start = 1'b1;
                    rreq.value = AB'(prod_reg) + AB'(part_reg);
                    fstep_next = 3'd1;
                end
                else if (rrsp.done)
                begin
                    res_next   = rrsp.rem;
                    valid_next = 1'b1;
                    state_next = armmp_pkg::ST_OUT;
                end
            end
            armmp_pkg::ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    valid_next = 1'b0;
                    state_next = armmp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = armmp_pkg::ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= armmp_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            fstep_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            fstep_reg <= fstep_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        tmp_reg  <= tmp_next;
        m_reg    <= m_next;
        c_reg    <= c_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
        part_reg <= part_next;
        prod_reg <= prod_next;
    end

    assign in_ch.ready       = (state_reg == armmp_pkg::ST_IDLE);
    assign out_ch.valid      = valid_reg;
    assign out_ch.term_value = res_reg;
endmodule
`default_nettype wire
